### hw/rtl/asfr_pkg.sv
// Package for the addressed serial frame receiver.
// Frame constants, register indexes and the config and result structs.
// No dependencies.
`default_nettype none

package asfr_pkg;

	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_AREA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MARK   = 2'd2;

	localparam logic [7:0] DEST_ROOM    = 8'd240;
	localparam logic [7:0] DEST_BED     = 8'd0;
	localparam logic [3:0] IDLE_RELOAD  = 4'd15;
	localparam logic [7:0] MIN_LEN_EXCL = 8'd7;
	localparam logic [7:0] SENDER_BYTES = 8'd3;

	typedef struct packed {
		logic [7:0] local_area_addr;
		logic [7:0] start_marker;
		logic [7:0] end_marker;
	} cfg_t;

	typedef struct packed {
		logic       frame_good;
		logic       frame_abort;
		logic       flush_rx;
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] sender_area;
		logic [7:0] sender_room;
		logic [7:0] sender_bed;
		logic [7:0] command_code;
		logic [7:0] payload_length;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/asfr_if.sv
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on asfr_pkg.
`default_nettype none

interface asfr_item_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface asfr_result_if;
	logic       valid;
	logic       ready;
	logic       frame_good;
	logic       frame_abort;
	logic       flush_rx;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic [7:0] sender_area;
	logic [7:0] sender_room;
	logic [7:0] sender_bed;
	logic [7:0] command_code;
	logic [7:0] payload_length;

	modport source (output valid, output frame_good, output frame_abort, output flush_rx,
		output payload_valid, output payload_byte, output sender_area, output sender_room,
		output sender_bed, output command_code, output payload_length, input ready);
	modport sink (input valid, input frame_good, input frame_abort, input flush_rx,
		input payload_valid, input payload_byte, input sender_area, input sender_room,
		input sender_bed, input command_code, input payload_length, output ready);
endinterface

interface asfr_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [asfr_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/asfr_cfg_regs.sv
// Configuration register file: local area address, start and end markers.
// Depends on asfr_pkg.
`default_nettype none

module asfr_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [asfr_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [7:0]                      wr_data,
	output asfr_pkg::cfg_t                       cfg
);

	asfr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				asfr_pkg::CFG_LOCAL_AREA: cfg_q.local_area_addr <= wr_data;
				asfr_pkg::CFG_START_MARK: cfg_q.start_marker    <= wr_data;
				asfr_pkg::CFG_END_MARK:   cfg_q.end_marker      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/asfr_parser.sv
// Frame parser: phase, checksum, counters and held header, one item per cycle
// while accept is high. Depends on asfr_pkg.
`default_nettype none

module asfr_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic           op,
	input  wire logic [7:0]     rx_byte,
	input  wire asfr_pkg::cfg_t cfg,
	output asfr_pkg::result_t   res
);

	typedef enum logic [3:0] {
		P_WAIT, P_SENDER, P_DST_AREA, P_DST_ROOM, P_DST_BED, P_CMD,
		P_LEN_HI, P_LEN_LO, P_PAYLOAD, P_SUM, P_END
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] left_q, left_d;
	logic [3:0] idle_q, idle_d;
	logic [7:0] area_q, area_d;
	logic [7:0] room_q, room_d;
	logic [7:0] bed_q, bed_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] len_q, len_d;
	logic       good, abort_f, flush, pvalid, drop;
	logic [7:0] pbyte;
	logic [7:0] sum_add;

	assign sum_add = sum_q + rx_byte;

	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		left_d  = left_q;
		idle_d  = idle_q;
		area_d  = area_q;
		room_d  = room_q;
		bed_d   = bed_q;
		cmd_d   = cmd_q;
		len_d   = len_q;
		good    = 1'b0;
		abort_f = 1'b0;
		flush   = 1'b0;
		pvalid  = 1'b0;
		pbyte   = 8'd0;
		drop    = 1'b0;
		if (op) begin
			if (idle_q == 4'd1) begin
				idle_d  = 4'd0;
				abort_f = (phase_q != P_WAIT);
				flush   = 1'b1;
				phase_d = P_WAIT;
			end else if (idle_q > 4'd1) begin
				idle_d = idle_q - 4'd1;
			end
		end else begin
			idle_d = asfr_pkg::IDLE_RELOAD;
			unique case (phase_q)
				P_WAIT: begin
					if (rx_byte == cfg.start_marker) begin
						sum_d   = 8'd0;
						left_d  = asfr_pkg::SENDER_BYTES;
						phase_d = P_SENDER;
					end
				end
				P_SENDER: begin
					sum_d = sum_add;
					if (left_q == 8'd3) area_d = rx_byte;
					else if (left_q == 8'd2) room_d = rx_byte;
					else bed_d = rx_byte;
					left_d = left_q - 8'd1;
					if (left_d == 8'd0) phase_d = P_DST_AREA;
				end
				P_DST_AREA: begin
					if (rx_byte == cfg.local_area_addr) begin
						sum_d   = sum_add;
						phase_d = P_DST_ROOM;
					end else begin
						drop = 1'b1;
					end
				end
				P_DST_ROOM: begin
					if (rx_byte == asfr_pkg::DEST_ROOM) begin
						sum_d   = sum_add;
						phase_d = P_DST_BED;
					end else begin
						drop = 1'b1;
					end
				end
				P_DST_BED: begin
					if (rx_byte == asfr_pkg::DEST_BED) begin
						sum_d   = sum_add;
						phase_d = P_CMD;
					end else begin
						drop = 1'b1;
					end
				end
				P_CMD: begin
					sum_d   = sum_add;
					cmd_d   = rx_byte;
					phase_d = P_LEN_HI;
				end
				P_LEN_HI: begin
					sum_d   = sum_add;
					phase_d = P_LEN_LO;
				end
				P_LEN_LO: begin
					sum_d  = sum_add;
					left_d = rx_byte;
					len_d  = rx_byte;
					if (rx_byte > asfr_pkg::MIN_LEN_EXCL) phase_d = P_PAYLOAD;
					else drop = 1'b1;
				end
				P_PAYLOAD: begin
					sum_d  = sum_add;
					pvalid = 1'b1;
					pbyte  = rx_byte;
					left_d = left_q - 8'd1;
					if (left_d == 8'd0) phase_d = P_SUM;
				end
				P_SUM: begin
					if (sum_q == rx_byte) phase_d = P_END;
					else drop = 1'b1;
				end
				P_END: begin
					if (rx_byte == cfg.end_marker) good = 1'b1;
					else abort_f = 1'b1;
					flush   = 1'b1;
					phase_d = P_WAIT;
				end
				default: drop = 1'b1;
			endcase
			if (drop) begin
				abort_f = 1'b1;
				flush   = 1'b1;
				phase_d = P_WAIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_WAIT;
			sum_q   <= '0;
			left_q  <= '0;
			idle_q  <= '0;
			area_q  <= '0;
			room_q  <= '0;
			bed_q   <= '0;
			cmd_q   <= '0;
			len_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			left_q  <= left_d;
			idle_q  <= idle_d;
			area_q  <= area_d;
			room_q  <= room_d;
			bed_q   <= bed_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
		end
	end

	always_comb begin
		res.frame_good     = good;
		res.frame_abort    = abort_f;
		res.flush_rx       = flush;
		res.payload_valid  = pvalid;
		res.payload_byte   = pbyte;
		res.sender_area    = area_d;
		res.sender_room    = room_d;
		res.sender_bed     = bed_d;
		res.command_code   = cmd_d;
		res.payload_length = len_d;
	end

`ifndef SYNTHESIS
	a_byte_reloads_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !op |=> idle_q == asfr_pkg::IDLE_RELOAD)
		else $error("idle countdown not reloaded by a byte");
	a_timeout_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op && idle_q == 4'd1 |=> phase_q == P_WAIT && idle_q == 4'd0)
		else $error("timeout did not return to wait");
	a_end_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !op && phase_q == P_END |=> phase_q == P_WAIT)
		else $error("end marker phase did not return to wait");
`endif

endmodule

`default_nettype wire

### hw/rtl/asfr_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
// Depends on asfr_pkg.
`default_nettype none

module asfr_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire asfr_pkg::result_t push_data,
	output logic                   can_push,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output asfr_pkg::result_t      out_data
);

	logic              out_valid_q, skid_valid_q;
	asfr_pkg::result_t out_q, skid_q;
	logic              pop;

	assign pop      = out_valid_q && out_ready;
	assign can_push = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) skid_valid_q <= 1'b0;
		end else if (push) begin
			if (out_valid_q && !pop) skid_valid_q <= 1'b1;
			else out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (push) begin
			if (out_valid_q && !pop) skid_q <= push_data;
			else out_q <= push_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without output entry");
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready && push))
		else $error("skid entry filled without a stall");
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_ready |=> out_valid_q && !skid_valid_q)
		else $error("skid entry not moved to output");
`endif

endmodule

`default_nettype wire

### hw/rtl/addressed_serial_frame_receiver_core.sv
// Addressed serial frame receiver, top level.
// A result is registered in the output register, or in the skid entry
// while the output stalls. Throughput: one item per cycle while the skid
// entry is free, so input stays ready while one result waits downstream.
// Reset (arst_n low, async): parser back to waiting, counters, header and
// config registers to zero, result buffer empty.
`default_nettype none

module addressed_serial_frame_receiver_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	asfr_item_if.sink     item,
	asfr_result_if.source result,
	asfr_cfg_if.sink      cfg
);

	asfr_pkg::cfg_t    cfg_regs;
	asfr_pkg::result_t res_d, res_q;
	logic              accept, can_push;

	assign cfg.ready  = 1'b1;
	assign item.ready = can_push;
	assign accept     = item.valid && can_push;

	asfr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	asfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.op      (item.op),
		.rx_byte (item.rx_byte),
		.cfg     (cfg_regs),
		.res     (res_d)
	);

	asfr_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res_d),
		.can_push  (can_push),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (res_q)
	);

	assign result.frame_good     = res_q.frame_good;
	assign result.frame_abort    = res_q.frame_abort;
	assign result.flush_rx       = res_q.flush_rx;
	assign result.payload_valid  = res_q.payload_valid;
	assign result.payload_byte   = res_q.payload_byte;
	assign result.sender_area    = res_q.sender_area;
	assign result.sender_room    = res_q.sender_room;
	assign result.sender_bed     = res_q.sender_bed;
	assign result.command_code   = res_q.command_code;
	assign result.payload_length = res_q.payload_length;

endmodule

`default_nettype wire
